// File: sv/bbbd_pkg.sv
// ----------------------------------------------------------------------------
// bbbd_pkg
// Shared types, constants and pixel conversion helpers of the blob detector.
// ----------------------------------------------------------------------------
package bbbd_pkg;

  localparam int unsigned DEF_MAX_WIDTH  = 64;
  localparam int unsigned DEF_MAX_HEIGHT = 64;

  localparam logic [6:0] WIDTH_RESET  = 7'd40;
  localparam logic [6:0] HEIGHT_RESET = 7'd30;

  localparam int unsigned QUEUE_DEPTH = 4;

  // register indexes on the configuration port
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  localparam logic [8:0] THR_OFFSET = 9'd24;
  localparam int unsigned MIN_SIDE  = 3;
  localparam int unsigned MIN_SHARE = 25;

  typedef struct packed {
    logic       last;
    logic [7:0] luma;
  } q_item_t;

  typedef struct packed {
    logic       found;
    logic [7:0] confidence;
    logic [7:0] box_x;
    logic [7:0] box_y;
    logic [7:0] box_w;
    logic [7:0] box_h;
  } res_t;

  // v*255/31 by reciprocal multiply, exact for every 5-bit v
  function automatic logic [7:0] expand5(input logic [4:0] v);
    logic [12:0] n;
    logic [26:0] p;
    n = {v, 8'd0} - {8'd0, v};
    p = 27'(n) * 27'd8457;
    return p[25:18];
  endfunction

  // v*255/63 by reciprocal multiply, exact for every 6-bit v
  function automatic logic [7:0] expand6(input logic [5:0] v);
    logic [13:0] n;
    logic [28:0] p;
    n = {v, 8'd0} - {8'd0, v};
    p = 29'(n) * 29'd16645;
    return p[27:20];
  endfunction

endpackage

// File: sv/bbbd_front.sv
// ----------------------------------------------------------------------------
// bbbd_front
// Pixel intake: widen RGB565 channels, weigh them into luma, push to queue.
// ----------------------------------------------------------------------------
module bbbd_front
  import bbbd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        pixel_valid_i,
  output logic        pixel_ready_o,
  input  logic [15:0] pixel_rgb565_i,
  input  logic        frame_end_i,
  output logic        push_o,
  output q_item_t     push_item_o,
  input  logic        q_ready_i
);

  logic       s1_v_q, s2_v_q;
  logic [7:0] r8_q, g8_q, b8_q;
  logic       s1_last_q;
  q_item_t    s2_item_q;
  logic       en;
  logic [15:0] wsum;

  assign en            = !s2_v_q || q_ready_i;
  assign pixel_ready_o = en;
  assign push_o        = s2_v_q;
  assign push_item_o   = s2_item_q;

  assign wsum = 16'(r8_q) * 16'd77 + 16'(g8_q) * 16'd150 + 16'(b8_q) * 16'd29;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
    end else if (en) begin
      s1_v_q <= pixel_valid_i;
      s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      r8_q           <= expand5(pixel_rgb565_i[15:11]);
      g8_q           <= expand6(pixel_rgb565_i[10:5]);
      b8_q           <= expand5(pixel_rgb565_i[4:0]);
      s1_last_q      <= frame_end_i;
      s2_item_q.luma <= wsum[15:8];
      s2_item_q.last <= s1_last_q;
    end
  end

endmodule

// File: sv/bbbd_fifo.sv
// ----------------------------------------------------------------------------
// bbbd_fifo
// Short queue of luma items between intake and frame evaluation.
// ----------------------------------------------------------------------------
module bbbd_fifo
  import bbbd_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  q_item_t data_i,
  output logic    ready_o,
  output logic    valid_o,
  output q_item_t data_o,
  input  logic    pop_i
);

  localparam int unsigned PW = $clog2(QUEUE_DEPTH);
  localparam int unsigned NW = $clog2(QUEUE_DEPTH + 1);

  q_item_t         slots_q [QUEUE_DEPTH];
  logic [PW-1:0]   wr_q, rd_q;
  logic [NW-1:0]   num_q;
  logic            do_push, do_pop;

  assign ready_o = num_q != NW'(QUEUE_DEPTH);
  assign valid_o = num_q != '0;
  assign data_o  = slots_q[rd_q];
  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      num_q <= '0;
    end else begin
      if (do_push) wr_q <= (wr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
      if (do_pop)  rd_q <= (rd_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
      if (do_push && !do_pop)      num_q <= num_q + 1'b1;
      else if (do_pop && !do_push) num_q <= num_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) slots_q[wr_q] <= data_i;
  end

endmodule

// File: sv/bbbd_div.sv
// ----------------------------------------------------------------------------
// bbbd_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bbbd_div #(
  parameter int unsigned DW = 29,
  parameter int unsigned VW = 21
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [DW-1:0] dividend_i,
  input  logic [VW-1:0] divisor_i,
  output logic          done_o,
  output logic [DW-1:0] quotient_o
);

  localparam int unsigned CNTW = $clog2(DW + 1);

  logic            busy_q, done_q;
  logic [CNTW-1:0] cnt_q;
  logic [VW-1:0]   rem_q, dvs_q;
  logic [DW-1:0]   quo_q;
  logic [VW:0]     trial, diff;
  logic            ge;

  assign trial      = {rem_q, quo_q[DW-1]};
  assign diff       = trial - {1'b0, dvs_q};
  assign ge         = trial >= {1'b0, dvs_q};
  assign done_o     = done_q;
  assign quotient_o = quo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= CNTW'(DW);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == CNTW'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= ge ? diff[VW-1:0] : trial[VW-1:0];
      quo_q <= {quo_q[DW-2:0], ge};
    end
  end

endmodule

// File: sv/bbbd_back.sv
// ----------------------------------------------------------------------------
// bbbd_back
// Frame evaluation: store luma, threshold, box scan, divisions, result.
// ----------------------------------------------------------------------------
module bbbd_back
  import bbbd_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = DEF_MAX_HEIGHT,
  localparam int unsigned XW = $clog2(MAX_WIDTH + 1),
  localparam int unsigned YW = $clog2(MAX_HEIGHT + 1)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic [XW-1:0] eff_w_i,
  input  logic [YW-1:0] eff_h_i,
  input  logic          q_valid_i,
  input  q_item_t       q_item_i,
  output logic          q_pop_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output res_t          out_o
);

  localparam int unsigned DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned CW    = $clog2(DEPTH + 1);
  localparam int unsigned SW    = CW + 8;

  typedef enum logic [3:0] {
    ST_LOAD, ST_MEAN, ST_SCAN, ST_TAIL, ST_CHECK,
    ST_CONT, ST_OCC, ST_X, ST_Y, ST_W, ST_H, ST_DONE
  } state_e;

  state_e        state_q;
  logic [7:0]    store_q [DEPTH];
  logic [7:0]    rd_q;
  logic [CW-1:0] count_q, loaded_q, idx_q, act_q;
  logic [SW-1:0] total_q, asum_q;
  logic [7:0]    peak_q, mean_q, thr_q, cont_q;
  logic [XW-1:0] x_q, rx_q, min_x_q, max_x_q, bw_q;
  logic [YW-1:0] y_q, ry_q, min_y_q, max_y_q, bh_q;
  logic          rv_q, rin_q, dbusy_q, ovalid_q;
  res_t          res_q, out_q;

  logic          wr_en, dstart, ddone, in_div;
  logic [SW-1:0] dividend, quo;
  logic [CW-1:0] divisor;
  logic [7:0]    lum;
  logic [8:0]    t9;
  logic [XW-1:0] bw;
  logic [YW-1:0] bh;
  logic [CW+4:0] need;
  logic [9:0]    conf;

  assign q_pop_o     = (state_q == ST_LOAD) && q_valid_i;
  assign wr_en       = q_pop_o && (loaded_q < count_q);
  assign out_valid_o = ovalid_q;
  assign out_o       = out_q;

  assign in_div = (state_q == ST_MEAN) || (state_q == ST_CONT) || (state_q == ST_OCC) ||
                  (state_q == ST_X) || (state_q == ST_Y) || (state_q == ST_W) ||
                  (state_q == ST_H);
  assign dstart = in_div && !dbusy_q && !((state_q == ST_MEAN) && (count_q == '0));

  always_comb begin
    dividend = total_q;
    divisor  = count_q;
    case (state_q)
      ST_CONT: begin
        dividend = asum_q;
        divisor  = act_q;
      end
      ST_OCC: begin
        dividend = {act_q, 8'd0} - SW'(act_q);
      end
      ST_X: begin
        dividend = {CW'(min_x_q), 8'd0} - SW'(min_x_q);
        divisor  = CW'(eff_w_i);
      end
      ST_Y: begin
        dividend = {CW'(min_y_q), 8'd0} - SW'(min_y_q);
        divisor  = CW'(eff_h_i);
      end
      ST_W: begin
        dividend = {CW'(bw_q), 8'd0} - SW'(bw_q);
        divisor  = CW'(eff_w_i);
      end
      ST_H: begin
        dividend = {CW'(bh_q), 8'd0} - SW'(bh_q);
        divisor  = CW'(eff_h_i);
      end
      default: begin
        dividend = total_q;
        divisor  = count_q;
      end
    endcase
  end

  bbbd_div #(.DW(SW), .VW(CW)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (dstart),
    .dividend_i (dividend),
    .divisor_i  (divisor),
    .done_o     (ddone),
    .quotient_o (quo)
  );

  assign lum  = rin_q ? rd_q : 8'd0;
  assign t9   = {1'b0, quo[7:0]} + THR_OFFSET;
  assign bw   = max_x_q - min_x_q + 1'b1;
  assign bh   = max_y_q - min_y_q + 1'b1;
  assign need = (CW+5)'(act_q + 1'b1) * (CW+5)'(MIN_SHARE);
  assign conf = 10'(cont_q) * 10'd3 + 10'(quo[7:0]);

  always_ff @(posedge clk_i) begin
    if (wr_en) store_q[loaded_q[AW-1:0]] <= q_item_i.luma;
    rd_q <= store_q[idx_q[AW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_LOAD;
      count_q  <= '0;
      loaded_q <= '0;
      total_q  <= '0;
      peak_q   <= '0;
      rv_q     <= 1'b0;
      dbusy_q  <= 1'b0;
      ovalid_q <= 1'b0;
      out_q    <= '0;
      res_q    <= '0;
      mean_q   <= '0;
      thr_q    <= '0;
      cont_q   <= '0;
      idx_q    <= '0;
      x_q      <= '0;
      y_q      <= '0;
      rx_q     <= '0;
      ry_q     <= '0;
      rin_q    <= 1'b0;
      min_x_q  <= '0;
      min_y_q  <= '0;
      max_x_q  <= '0;
      max_y_q  <= '0;
      act_q    <= '0;
      asum_q   <= '0;
      bw_q     <= '0;
      bh_q     <= '0;
    end else begin
      count_q <= CW'(eff_w_i) * CW'(eff_h_i);
      if ((state_q == ST_DONE) && (!ovalid_q || out_ready_i)) ovalid_q <= 1'b1;
      else if (out_ready_i) ovalid_q <= 1'b0;
      if (dstart) dbusy_q <= 1'b1;
      else if (ddone) dbusy_q <= 1'b0;

      // compare stage of the scan
      rv_q <= (state_q == ST_SCAN);
      if (rv_q && (lum >= thr_q)) begin
        if (rx_q < min_x_q) min_x_q <= rx_q;
        if (ry_q < min_y_q) min_y_q <= ry_q;
        if (rx_q > max_x_q) max_x_q <= rx_q;
        if (ry_q > max_y_q) max_y_q <= ry_q;
        act_q  <= act_q + 1'b1;
        asum_q <= asum_q + SW'(lum);
      end

      case (state_q)
        ST_LOAD: begin
          if (wr_en) begin
            loaded_q <= loaded_q + 1'b1;
            total_q  <= total_q + SW'(q_item_i.luma);
            if (q_item_i.luma > peak_q) peak_q <= q_item_i.luma;
          end
          if (q_pop_o && q_item_i.last) begin
            res_q   <= '0;
            state_q <= ST_MEAN;
          end
        end
        ST_MEAN: begin
          if (count_q == '0) begin
            state_q <= ST_DONE;
          end else if (ddone) begin
            mean_q  <= quo[7:0];
            thr_q   <= (t9[8] || (t9[7:0] > peak_q)) ? peak_q : t9[7:0];
            idx_q   <= '0;
            x_q     <= '0;
            y_q     <= '0;
            min_x_q <= eff_w_i;
            min_y_q <= eff_h_i;
            max_x_q <= '0;
            max_y_q <= '0;
            act_q   <= '0;
            asum_q  <= '0;
            state_q <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          rx_q  <= x_q;
          ry_q  <= y_q;
          rin_q <= idx_q < loaded_q;
          idx_q <= idx_q + 1'b1;
          if (x_q == eff_w_i - 1'b1) begin
            x_q <= '0;
            y_q <= y_q + 1'b1;
            if (y_q == eff_h_i - 1'b1) state_q <= ST_TAIL;
          end else begin
            x_q <= x_q + 1'b1;
          end
        end
        ST_TAIL: begin
          state_q <= ST_CHECK;
        end
        ST_CHECK: begin
          bw_q <= bw;
          bh_q <= bh;
          if ((act_q == '0) || (need <= (CW+5)'(count_q)) ||
              (bw < XW'(MIN_SIDE)) || (bh < YW'(MIN_SIDE))) begin
            state_q <= ST_DONE;
          end else begin
            state_q <= ST_CONT;
          end
        end
        ST_CONT: begin
          if (ddone) begin
            cont_q  <= quo[7:0] - mean_q;
            state_q <= ST_OCC;
          end
        end
        ST_OCC: begin
          if (ddone) begin
            res_q.found      <= 1'b1;
            res_q.confidence <= conf[9:8] != 2'b00 ? 8'hFF : conf[7:0];
            state_q          <= ST_X;
          end
        end
        ST_X: begin
          if (ddone) begin
            res_q.box_x <= quo[7:0];
            state_q     <= ST_Y;
          end
        end
        ST_Y: begin
          if (ddone) begin
            res_q.box_y <= quo[7:0];
            state_q     <= ST_W;
          end
        end
        ST_W: begin
          if (ddone) begin
            res_q.box_w <= quo[7:0];
            state_q     <= ST_H;
          end
        end
        ST_H: begin
          if (ddone) begin
            res_q.box_h <= quo[7:0];
            state_q     <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (!ovalid_q || out_ready_i) begin
            out_q    <= res_q;
            loaded_q <= '0;
            total_q  <= '0;
            peak_q   <= '0;
            state_q  <= ST_LOAD;
          end
        end
        default: begin
          state_q <= ST_LOAD;
        end
      endcase
    end
  end

`ifndef SYNTH
  // the queue is drained only while loading pixels
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |-> (state_q == ST_LOAD))
    else $error("queue popped outside load");

  // never restart the divider while it is working
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    dstart |=> !dstart)
    else $error("divider restarted while busy");

  // a found blob always has a non-empty box
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ovalid_q && out_q.found) |-> (out_q.box_w != 8'd0) && (out_q.box_h != 8'd0))
    else $error("found blob with empty box");
`endif

endmodule

// File: sv/bright_blob_box_detector_core.sv
// ----------------------------------------------------------------------------
// bright_blob_box_detector_core
// Bright blob bounding box detector over an RGB565 frame.
// ----------------------------------------------------------------------------
// Pixels enter row-major on the pixel channel, one per cycle while intake
// is not stalled, and are turned into 8-bit luma in a two-stage intake
// pipeline that feeds a four-entry queue. The evaluation side writes each
// luma up to the frame size into an on-chip frame store while summing it
// and tracking the peak. The pixel flagged frame_end starts the frame
// evaluation: one division for the mean, a scan of the store at one pixel
// per cycle (set by the single read port), and, for a blob that passes the
// size and share checks, six more divisions for contrast, occupancy and the
// four box fields. Intake stalls once the queue fills during evaluation.
// Each frame produces exactly one result request; it waits in an output
// register, so pixels of the next frame keep loading while it is not yet
// taken. frame_width and frame_height sit at byte addresses 0 and 4 of the
// APB port; change them only while no frame is in flight.
// ----------------------------------------------------------------------------
module bright_blob_box_detector_core
  import bbbd_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // APB configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // pixel channel
  input  logic        pixel_valid_i,
  output logic        pixel_ready_o,
  input  logic [15:0] pixel_rgb565_i,
  input  logic        frame_end_i,
  // result channel
  output logic        result_valid_o,
  input  logic        result_ready_i,
  output logic        found_o,
  output logic [7:0]  confidence_o,
  output logic [7:0]  box_x_o,
  output logic [7:0]  box_y_o,
  output logic [7:0]  box_w_o,
  output logic [7:0]  box_h_o
);

  localparam int unsigned XW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned YW = $clog2(MAX_HEIGHT + 1);

  logic [6:0]    width_q, height_q;
  logic [XW-1:0] eff_w;
  logic [YW-1:0] eff_h;
  logic          push, q_ready, q_valid, q_pop;
  q_item_t       push_item, q_item;
  res_t          res;

  // register file: writes complete in the access phase
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_HEIGHT) ? {25'd0, height_q} : {25'd0, width_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RESET;
      height_q <= HEIGHT_RESET;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == REG_WIDTH) width_q <= pwdata[6:0];
      else                       height_q <= pwdata[6:0];
    end
  end

  // clamp the frame size to the store
  assign eff_w = ({25'd0, width_q} > 32'(MAX_WIDTH)) ? XW'(MAX_WIDTH) : XW'(width_q);
  assign eff_h = ({25'd0, height_q} > 32'(MAX_HEIGHT)) ? YW'(MAX_HEIGHT) : YW'(height_q);

  bbbd_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .pixel_valid_i  (pixel_valid_i),
    .pixel_ready_o  (pixel_ready_o),
    .pixel_rgb565_i (pixel_rgb565_i),
    .frame_end_i    (frame_end_i),
    .push_o         (push),
    .push_item_o    (push_item),
    .q_ready_i      (q_ready)
  );

  bbbd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_item),
    .ready_o (q_ready),
    .valid_o (q_valid),
    .data_o  (q_item),
    .pop_i   (q_pop)
  );

  bbbd_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .eff_w_i     (eff_w),
    .eff_h_i     (eff_h),
    .q_valid_i   (q_valid),
    .q_item_i    (q_item),
    .q_pop_o     (q_pop),
    .out_valid_o (result_valid_o),
    .out_ready_i (result_ready_i),
    .out_o       (res)
  );

  assign found_o      = res.found;
  assign confidence_o = res.confidence;
  assign box_x_o      = res.box_x;
  assign box_y_o      = res.box_y;
  assign box_w_o      = res.box_w;
  assign box_h_o      = res.box_h;

endmodule

// File: sim/tb_bright_blob_box_detector_core.sv
// ----------------------------------------------------------------------------
// tb_bright_blob_box_detector_core
// Self-checking bench for the bright blob bounding box detector.
// ----------------------------------------------------------------------------
// Frames are streamed into the pixel channel while the frame size is changed
// over the APB port between frames. Most frames hold a bright rectangle on a
// dark background, and the rest are noise, truncated frames, or frames with
// trailing extra pixels. Each accepted pixel goes into a luma predictor. Each
// frame_end pushes one expected detection, and every accepted result is
// compared field by field against the oldest expected detection.
// ----------------------------------------------------------------------------
class blob_result_board;
  bbbd_pkg::res_t   expected_boxes[$];
  bit [7:0]         luma_mem[4096];
  int unsigned      luma_sum, luma_max, pixels_in;
  int unsigned      cfg_width, cfg_height;
  int unsigned      errors, detections, frames;

  function void reset_state();
    luma_sum = 0; luma_max = 0; pixels_in = 0;
    cfg_width = 40; cfg_height = 30;
  endfunction

  function int unsigned eff_w();
    return (cfg_width > 64) ? 64 : cfg_width;
  endfunction

  function int unsigned eff_h();
    return (cfg_height > 64) ? 64 : cfg_height;
  endfunction

  function int unsigned pixel_luma(bit [15:0] px);
    int unsigned r8, g8, b8;
    r8 = (px[15:11] * 255) / 31;
    g8 = (px[10:5] * 255) / 63;
    b8 = (px[4:0] * 255) / 31;
    return ((r8 * 77 + g8 * 150 + b8 * 29) >> 8) & 8'hFF;
  endfunction

  function int unsigned scale_pos(int unsigned v, int unsigned lim, bit is_edge);
    if (lim == 0) return 0;
    if (is_edge && v >= lim) v = lim - 1;
    if (!is_edge && v > lim) v = lim;
    return ((v * 255) / lim) & 8'hFF;
  endfunction

  // Scan the stored frame and predict the detection
  function bbbd_pkg::res_t predict_box();
    bbbd_pkg::res_t r;
    int unsigned w, h, n, mean, thr, lx, ly, hx, hy, act, asum, l, bw, bh, conf;
    r = '0;
    w = eff_w(); h = eff_h(); n = w * h;
    if (n == 0) return r;
    mean = (luma_sum / n) & 8'hFF;
    thr = mean + 24;
    if (thr > 255 || thr > luma_max) thr = luma_max;
    lx = w; ly = h; hx = 0; hy = 0; act = 0; asum = 0;
    for (int unsigned y = 0; y < h; y++) begin
      for (int unsigned x = 0; x < w; x++) begin
        l = (y * w + x < pixels_in) ? luma_mem[y * w + x] : 0;
        if (l >= thr) begin
          if (x < lx) lx = x;
          if (y < ly) ly = y;
          if (x > hx) hx = x;
          if (y > hy) hy = y;
          act++;
          asum += l;
        end
      end
    end
    if (act == 0 || act < n / 25 || lx >= w || ly >= h) return r;
    bw = hx - lx + 1;
    bh = hy - ly + 1;
    if (bw < 3 || bh < 3) return r;
    conf = (((asum / act) - mean) & 8'hFF) * 3 + (act * 255) / n;
    r.found      = 1'b1;
    r.confidence = (conf > 255) ? 8'd255 : conf[7:0];
    r.box_x      = scale_pos(lx, w, 1'b1);
    r.box_y      = scale_pos(ly, h, 1'b1);
    r.box_w      = scale_pos(bw, w, 1'b0);
    r.box_h      = scale_pos(bh, h, 1'b0);
    return r;
  endfunction

  function void note_pixel(bit [15:0] px, bit last);
    int unsigned l;
    if (pixels_in < eff_w() * eff_h() && pixels_in < 4096) begin
      l = pixel_luma(px);
      luma_mem[pixels_in] = l[7:0];
      luma_sum += l;
      if (l > luma_max) luma_max = l;
      pixels_in++;
    end
    if (last) begin
      expected_boxes.push_back(predict_box());
      luma_sum = 0; luma_max = 0; pixels_in = 0;
      frames++;
    end
  endfunction

  function void check_result(bbbd_pkg::res_t act);
    bbbd_pkg::res_t e;
    if (expected_boxes.size() == 0) begin
      $error("unexpected result request, found=%0d", act.found);
      errors++;
      return;
    end
    e = expected_boxes.pop_front();
    if (act.found) detections++;
    if (act.found != e.found) begin
      $error("found: expected %0d actual %0d", e.found, act.found); errors++;
    end
    if (act.confidence != e.confidence) begin
      $error("confidence: expected %0d actual %0d", e.confidence, act.confidence); errors++;
    end
    if (act.box_x != e.box_x) begin
      $error("box_x: expected %0d actual %0d", e.box_x, act.box_x); errors++;
    end
    if (act.box_y != e.box_y) begin
      $error("box_y: expected %0d actual %0d", e.box_y, act.box_y); errors++;
    end
    if (act.box_w != e.box_w) begin
      $error("box_w: expected %0d actual %0d", e.box_w, act.box_w); errors++;
    end
    if (act.box_h != e.box_h) begin
      $error("box_h: expected %0d actual %0d", e.box_h, act.box_h); errors++;
    end
  endfunction
endclass

module tb_bright_blob_box_detector_core;
  import bbbd_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 3000000;
  localparam int unsigned PIXEL_TARGET = 1650;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        pixel_valid_i = 1'b0;
  logic        pixel_ready_o;
  logic [15:0] pixel_rgb565_i = '0;
  logic        frame_end_i = 1'b0;
  logic        result_valid_o;
  logic        result_ready_i = 1'b0;
  logic        found_o;
  logic [7:0]  confidence_o, box_x_o, box_y_o, box_w_o, box_h_o;

  blob_result_board board = new();
  int unsigned      cycles = 0;
  int unsigned      pixels_sent = 0;
  bit               stall_free = 1'b0;

  bright_blob_box_detector_core dut (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .pixel_valid_i, .pixel_ready_o, .pixel_rgb565_i, .frame_end_i,
    .result_valid_o, .result_ready_i, .found_o, .confidence_o,
    .box_x_o, .box_y_o, .box_w_o, .box_h_o
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_bright_blob_box_detector_core failed");
      $finish;
    end
  end

  // Mostly short gaps, a few long ones; none at all during quiet stretches
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(99);
    if (stall_free || roll < 65) return 0;
    if (roll < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Stall the result side at random
  always @(posedge clk_i) begin
    if (rst_ni) result_ready_i <= (pick_gap() == 0);
  end

  // Check every accepted result request
  always @(posedge clk_i) begin
    res_t act;
    if (rst_ni && result_valid_o && result_ready_i) begin
      act = '{found_o, confidence_o, box_x_o, box_y_o, box_w_o, box_h_o};
      board.check_result(act);
    end
  end

  task automatic write_reg(logic idx, logic [6:0] value);
    @(posedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= {25'd0, value};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    // register is written at this edge
    if (idx == REG_WIDTH) board.cfg_width = value;
    else board.cfg_height = value;
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  // Hold the pixel request until accepted; drop valid only ahead of a gap
  task automatic send_pixel(logic [15:0] px, logic last);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      pixel_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    pixel_valid_i <= 1'b1;
    pixel_rgb565_i <= px;
    frame_end_i <= last;
    do @(posedge clk_i); while (!pixel_ready_o);
    board.note_pixel(px, last);
    pixels_sent++;
  endtask

  // Drop the pixel request, then wait for every outstanding result
  task automatic drain();
    pixel_valid_i <= 1'b0;
    while (board.expected_boxes.size() != 0) @(posedge clk_i);
    // a frame cannot be in flight here, but leave slack anyway
    repeat (40) @(posedge clk_i);
  endtask

  task automatic set_size(logic [6:0] w, logic [6:0] h);
    drain();
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, h);
  endtask

  // Send one frame: a bright rectangle on dark noise, or a damaged variant
  task automatic send_frame();
    int unsigned w, h, n, bx, by, bw, bh, kind, stop, extra;
    logic [15:0] px;
    w = board.eff_w(); h = board.eff_h(); n = w * h;
    kind = $urandom_range(99);
    bw = (w > 0) ? $urandom_range(1, w) : 0;
    bh = (h > 0) ? $urandom_range(1, h) : 0;
    bx = (w > bw) ? $urandom_range(0, w - bw) : 0;
    by = (h > bh) ? $urandom_range(0, h - bh) : 0;
    stop = (kind >= 80 && kind < 90 && n > 1) ? $urandom_range(1, n - 1) : n;
    extra = (kind >= 90) ? $urandom_range(1, 6) : 0;
    if (stop + extra == 0) extra = 1;
    for (int unsigned i = 0; i < stop + extra; i++) begin
      if (kind >= 70 && kind < 80) px = $urandom;
      else if (i < n && (i % w) >= bx && (i % w) < bx + bw && (i / w) >= by
               && (i / w) < by + bh)
        px = $urandom | 16'hC618;
      else px = $urandom & 16'h39E7;
      send_pixel(px, i == stop + extra - 1);
    end
  endtask

  initial begin
    logic [15:0] corner[9];
    int unsigned wv, hv;
    corner = '{16'h0000, 16'hFFFF, 16'hF800, 16'h07E0, 16'h001F,
               16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF};
    board.reset_state();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: 3x3 extremes, zero size, oversized width, missing pixels
    set_size(7'd3, 7'd3);
    foreach (corner[i]) send_pixel(corner[i], i == 8);
    foreach (corner[i]) send_pixel(~corner[i], i == 8);
    set_size(7'd0, 7'd5);
    send_pixel(16'hFFFF, 1'b1);
    set_size(7'd127, 7'd1);
    send_pixel(16'hFFFF, 1'b0);
    send_pixel(16'h0000, 1'b1);
    set_size(7'd4, 7'd0);
    send_pixel(16'h5555, 1'b1);

    // Extreme sizes, then mostly small random sizes
    set_size(7'd64, 7'd8);
    send_frame();
    set_size(7'd127, 7'd3);
    send_frame();
    set_size(7'd3, 7'd127);
    send_frame();
    while (pixels_sent < PIXEL_TARGET) begin
      wv = ($urandom_range(9) == 0) ? $urandom_range(0, 127) : $urandom_range(1, 12);
      hv = ($urandom_range(9) == 0) ? $urandom_range(0, 20) : $urandom_range(1, 12);
      set_size(wv[6:0], hv[6:0]);
      stall_free = ($urandom_range(4) == 0);
      repeat ($urandom_range(1, 4)) send_frame();
    end
    stall_free = 1'b0;

    drain();
    repeat (200) @(posedge clk_i);
    if (board.expected_boxes.size() != 0) begin
      $error("%0d expected results never arrived", board.expected_boxes.size());
      board.errors++;
    end
    $display("Covered %0d pixels in %0d frames, %0d with a blob found, %0d errors.",
             pixels_sent, board.frames, board.detections, board.errors);
    if (board.errors == 0) begin
      $display("tb_bright_blob_box_detector_core passed");
    end else begin
      $display("tb_bright_blob_box_detector_core failed");
    end
    $finish;
  end
endmodule
